// ----- rtl/frem_pkg.sv -----
// Shared types, codes and constants of the feature range envelope monitor.
`default_nettype none

package frem_pkg;

    localparam int MAX_FEATURES_DEF = 64;

    localparam int FCOUNT_W = 7;
    localparam int DATA_W   = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_VEC_LENGTH      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ENVELOPE_ENABLE = 1'b1;

    localparam logic signed [DATA_W-1:0] MIN_SENTINEL = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] MAX_SENTINEL = 32'sh8000_0000;

    typedef enum logic [2:0] {
        KIND_SAMPLE = 3'd0,
        KIND_LOAD   = 3'd1,
        KIND_WINDOW = 3'd2,
        KIND_READ   = 3'd3,
        KIND_CHECK  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_VIOLATION = 2'd1,
        STATUS_BAD_INDEX = 2'd2
    } status_t;

    // Per-feature statistics record held in the statistics memory.
    typedef struct packed {
        logic signed [DATA_W-1:0] min_val;
        logic signed [DATA_W-1:0] max_val;
        logic [DATA_W-1:0]        samples;
        logic [DATA_W-1:0]        violations;
    } stat_rec_t;

    // Per-feature bounds record held in the bounds memory.
    typedef struct packed {
        logic signed [DATA_W-1:0] upper;
        logic signed [DATA_W-1:0] lower;
    } bound_rec_t;

    localparam int STAT_W  = $bits(stat_rec_t);
    localparam int BOUND_W = $bits(bound_rec_t);

    // Control of the transaction sitting in the update stage.
    typedef struct packed {
        logic  valid;
        kind_t kind;
        logic  last;
        logic  bad_index;
    } s1_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/frem_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module frem_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/frem_front.sv -----
// Accept stage: element position, memory addressing, bounds loading and the stage register.
`default_nettype none

module frem_front import frem_pkg::*; #(
    parameter int MAX_FEATURES = MAX_FEATURES_DEF,
    parameter int ADDR_W       = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [FCOUNT_W-1:0]  vec_length,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [2:0]           s_kind,
    input  wire logic [5:0]           s_feature_index,
    input  wire logic signed [31:0]   s_value,
    input  wire logic signed [31:0]   s_upper_value,
    input  wire logic [63:0]          s_window_label,
    input  wire logic                 s1_fire,
    output logic                      bound_we,
    output logic [ADDR_W-1:0]         bound_waddr,
    output bound_rec_t                bound_wdata,
    output logic                      rd_en,
    output logic [ADDR_W-1:0]         rd_addr,
    output s1_ctrl_t                  s1,
    output logic [ADDR_W-1:0]         s1_addr,
    output logic signed [DATA_W-1:0]  s1_value
);

    localparam int CNT_W = $clog2(MAX_FEATURES + 1);
    localparam int CMP_W = ((CNT_W > FCOUNT_W) ? CNT_W : FCOUNT_W) + 1;

    logic [ADDR_W-1:0] pos_reg, pos_next;
    s1_ctrl_t          s1_reg, s1_next;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic signed [DATA_W-1:0] s1_value_reg;
    logic [63:0]       window_id_reg;

    kind_t             in_kind;
    logic              accept;
    logic [CMP_W-1:0]  fc_ext, max_ext, cnt, idx_ext, pos_plus1;
    logic              last_elem, bad_index, load_ok;
    logic [ADDR_W-1:0] idx_addr;

    assign in_kind = kind_t'(s_kind);
    assign s_ready = !s1_reg.valid || s1_fire;
    assign accept  = s_valid && s_ready;

    // A count of zero behaves as one, a count above the memory depth as the depth.
    assign fc_ext  = CMP_W'(vec_length);
    assign max_ext = CMP_W'(MAX_FEATURES);
    always_comb begin
        if (fc_ext == '0) begin
            cnt = CMP_W'(1);
        end else if (fc_ext > max_ext) begin
            cnt = max_ext;
        end else begin
            cnt = fc_ext;
        end
    end

    assign idx_ext   = CMP_W'(s_feature_index);
    assign idx_addr  = ADDR_W'(s_feature_index);
    assign pos_plus1 = CMP_W'(pos_reg) + CMP_W'(1);
    assign last_elem = (pos_plus1 >= cnt);
    assign bad_index = (idx_ext >= cnt);
    assign load_ok   = (idx_ext < max_ext);

    assign bound_we    = accept && (in_kind == KIND_LOAD) && load_ok;
    assign bound_waddr = idx_addr;
    assign bound_wdata = '{upper: s_upper_value, lower: s_value};

    assign rd_en   = accept;
    assign rd_addr = (in_kind == KIND_SAMPLE) ? pos_reg : idx_addr;

    always_comb begin
        pos_next = pos_reg;
        s1_next  = s1_reg;
        if (s1_fire) begin
            s1_next.valid = 1'b0;
        end
        if (accept) begin
            s1_next.valid     = 1'b1;
            s1_next.kind      = in_kind;
            s1_next.last      = last_elem;
            s1_next.bad_index = bad_index;
            if (in_kind == KIND_SAMPLE) begin
                pos_next = last_elem ? '0 : pos_plus1[ADDR_W-1:0];
            end else if (in_kind == KIND_WINDOW) begin
                pos_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            s1_reg       <= '0;
            window_id_reg <= '0;
        end else begin
            pos_reg <= pos_next;
            s1_reg  <= s1_next;
            if (accept && (in_kind == KIND_WINDOW)) begin
                window_id_reg <= s_window_label;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_addr_reg  <= rd_addr;
            s1_value_reg <= s_value;
        end
    end

    assign s1       = s1_reg;
    assign s1_addr  = s1_addr_reg;
    assign s1_value = s1_value_reg;

endmodule

`default_nettype wire

// ----- rtl/frem_update.sv -----
// Update stage: statistics read-modify-write, envelope checks, vector state and result register.
`default_nettype none

module frem_update import frem_pkg::*; #(
    parameter int MAX_FEATURES = MAX_FEATURES_DEF,
    parameter int ADDR_W       = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 envelope_enable,
    input  wire s1_ctrl_t             s1,
    input  wire logic [ADDR_W-1:0]    s1_addr,
    input  wire logic signed [DATA_W-1:0] s1_value,
    input  wire stat_rec_t            stat_rdata,
    input  wire bound_rec_t           bound_rdata,
    output logic                      stat_we,
    output logic [ADDR_W-1:0]         stat_waddr,
    output stat_rec_t                 stat_wdata,
    output logic                      s1_fire,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [1:0]                m_status,
    output logic [6:0]                m_vector_violations,
    output logic [5:0]                m_first_feature,
    output logic signed [31:0]        m_first_value,
    output logic signed [31:0]        m_first_bound,
    output logic                      m_first_is_upper,
    output logic signed [31:0]        m_stat_min,
    output logic signed [31:0]        m_stat_max,
    output logic [31:0]               m_stat_samples,
    output logic [31:0]               m_stat_violations,
    output logic [31:0]               m_window_vectors,
    output logic [31:0]               m_window_violations
);

    localparam int CNT_W   = $clog2(MAX_FEATURES + 1);
    localparam int TALLY_W = (CNT_W > 7) ? CNT_W : 7;

    // Entry valid bits and last-write forwarding for the statistics memory.
    logic [MAX_FEATURES-1:0] entry_valid_reg, entry_valid_next;
    logic                    fwd_valid_reg, fwd_valid_next;
    logic [ADDR_W-1:0]       fwd_addr_reg;
    stat_rec_t               fwd_data_reg;

    logic [DATA_W-1:0]       win_samples_reg, win_samples_next;
    logic [DATA_W-1:0]       win_viol_reg, win_viol_next;
    logic [TALLY_W-1:0]      tally_reg, tally_next;
    logic                    found_reg, found_next;
    logic [ADDR_W-1:0]       held_feature_reg, held_feature_next;
    logic signed [DATA_W-1:0] held_value_reg, held_value_next;
    logic signed [DATA_W-1:0] held_bound_reg, held_bound_next;
    logic                    held_upper_reg, held_upper_next;

    logic                    m_valid_reg, m_valid_next;
    logic [1:0]              status_reg, status_next;
    logic [6:0]              vec_viol_reg, vec_viol_next;
    logic [5:0]              first_feature_reg, first_feature_next;
    logic signed [31:0]      first_value_reg, first_bound_reg;
    logic signed [31:0]      first_value_next, first_bound_next;
    logic                    first_upper_reg, first_upper_next;
    logic signed [31:0]      stat_min_reg, stat_max_reg;
    logic signed [31:0]      stat_min_next, stat_max_next;
    logic [31:0]             stat_samples_reg, stat_viol_reg;
    logic [31:0]             stat_samples_next, stat_viol_next;
    logic [31:0]             win_samples_out_reg, win_viol_out_reg;
    logic [31:0]             win_samples_out_next, win_viol_out_next;

    stat_rec_t               stat_cur, stat_new;
    logic                    below, above, hit;
    logic [TALLY_W-1:0]      tally_inc;
    logic                    take_first;
    logic [ADDR_W-1:0]       first_feature_sel;
    logic signed [DATA_W-1:0] first_value_sel, first_bound_sel;
    logic                    first_upper_sel;
    logic                    has_result, out_free, load_out;
    status_t                 status_c;
    logic                    in_range;

    always_comb begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_addr)) begin
            stat_cur = fwd_data_reg;
        end else if (entry_valid_reg[s1_addr]) begin
            stat_cur = stat_rdata;
        end else begin
            stat_cur = '{min_val: MIN_SENTINEL, max_val: MAX_SENTINEL,
                         samples: '0, violations: '0};
        end
    end

    assign below    = (s1_value < bound_rdata.lower);
    assign above    = !below && (s1_value > bound_rdata.upper);
    assign hit      = envelope_enable && (below || above);
    assign in_range = (s1_value >= bound_rdata.lower) && (s1_value <= bound_rdata.upper);

    always_comb begin
        stat_new            = stat_cur;
        stat_new.samples    = stat_cur.samples + DATA_W'(1);
        stat_new.violations = stat_cur.violations + DATA_W'(hit);
        if (s1_value < stat_cur.min_val) begin
            stat_new.min_val = s1_value;
        end
        if (s1_value > stat_cur.max_val) begin
            stat_new.max_val = s1_value;
        end
    end

    assign tally_inc  = tally_reg + TALLY_W'(hit);
    assign take_first = hit && !found_reg;
    assign first_feature_sel = take_first ? s1_addr : held_feature_reg;
    assign first_value_sel   = take_first ? s1_value : held_value_reg;
    assign first_bound_sel   = take_first ? (below ? bound_rdata.lower : bound_rdata.upper)
                                          : held_bound_reg;
    assign first_upper_sel   = take_first ? !below : held_upper_reg;

    always_comb begin
        unique case (s1.kind)
            KIND_SAMPLE: has_result = s1.last;
            KIND_READ:   has_result = 1'b1;
            KIND_CHECK:  has_result = 1'b1;
            default:     has_result = 1'b0;
        endcase
    end

    assign out_free = !m_valid_reg || m_ready;
    assign s1_fire  = s1.valid && (!has_result || out_free);
    assign load_out = s1_fire && has_result;

    assign stat_we    = s1_fire && (s1.kind == KIND_SAMPLE);
    assign stat_waddr = s1_addr;
    assign stat_wdata = stat_new;

    always_comb begin
        if (!envelope_enable) begin
            status_c = STATUS_OK;
        end else if (s1.bad_index) begin
            status_c = STATUS_BAD_INDEX;
        end else begin
            status_c = in_range ? STATUS_OK : STATUS_VIOLATION;
        end
    end

    always_comb begin
        entry_valid_next  = entry_valid_reg;
        fwd_valid_next    = fwd_valid_reg;
        win_samples_next  = win_samples_reg;
        win_viol_next     = win_viol_reg;
        tally_next        = tally_reg;
        found_next        = found_reg;
        held_feature_next = held_feature_reg;
        held_value_next   = held_value_reg;
        held_bound_next   = held_bound_reg;
        held_upper_next   = held_upper_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        if (load_out) begin
            m_valid_next = 1'b1;
        end
        if (s1_fire) begin
            fwd_valid_next = stat_we;
            if (s1.kind == KIND_SAMPLE) begin
                entry_valid_next[s1_addr] = 1'b1;
                win_viol_next = win_viol_reg + DATA_W'(hit);
                if (s1.last) begin
                    win_samples_next  = win_samples_reg + DATA_W'(1);
                    tally_next        = '0;
                    found_next        = 1'b0;
                    held_feature_next = '0;
                    held_value_next   = '0;
                    held_bound_next   = '0;
                    held_upper_next   = 1'b0;
                end else begin
                    tally_next        = tally_inc;
                    found_next        = found_reg || hit;
                    held_feature_next = first_feature_sel;
                    held_value_next   = first_value_sel;
                    held_bound_next   = first_bound_sel;
                    held_upper_next   = first_upper_sel;
                end
            end else if (s1.kind == KIND_WINDOW) begin
                entry_valid_next  = '0;
                win_samples_next  = '0;
                win_viol_next     = '0;
                tally_next        = '0;
                found_next        = 1'b0;
                held_feature_next = '0;
                held_value_next   = '0;
                held_bound_next   = '0;
                held_upper_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg  <= '0;
            fwd_valid_reg    <= 1'b0;
            win_samples_reg  <= '0;
            win_viol_reg     <= '0;
            tally_reg        <= '0;
            found_reg        <= 1'b0;
            held_feature_reg <= '0;
            held_value_reg   <= '0;
            held_bound_reg   <= '0;
            held_upper_reg   <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            entry_valid_reg  <= entry_valid_next;
            fwd_valid_reg    <= fwd_valid_next;
            win_samples_reg  <= win_samples_next;
            win_viol_reg     <= win_viol_next;
            tally_reg        <= tally_next;
            found_reg        <= found_next;
            held_feature_reg <= held_feature_next;
            held_value_reg   <= held_value_next;
            held_bound_reg   <= held_bound_next;
            held_upper_reg   <= held_upper_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (stat_we) begin
            fwd_addr_reg <= s1_addr;
            fwd_data_reg <= stat_new;
        end
    end

    // Result fields; the ones a transaction kind does not fill stay zero.
    always_comb begin
        status_next          = STATUS_OK;
        vec_viol_next        = '0;
        first_feature_next   = '0;
        first_value_next     = '0;
        first_bound_next     = '0;
        first_upper_next     = 1'b0;
        stat_min_next        = '0;
        stat_max_next        = '0;
        stat_samples_next    = '0;
        stat_viol_next       = '0;
        win_samples_out_next = '0;
        win_viol_out_next    = '0;
        unique case (s1.kind)
            KIND_SAMPLE: begin
                status_next        = (tally_inc != '0) ? STATUS_VIOLATION : STATUS_OK;
                vec_viol_next      = tally_inc[6:0];
                first_feature_next = 6'(first_feature_sel);
                first_value_next   = first_value_sel;
                first_bound_next   = first_bound_sel;
                first_upper_next   = first_upper_sel;
            end
            KIND_READ: begin
                win_samples_out_next = win_samples_reg;
                win_viol_out_next    = win_viol_reg;
                if (s1.bad_index) begin
                    status_next = STATUS_BAD_INDEX;
                end else begin
                    stat_min_next     = stat_cur.min_val;
                    stat_max_next     = stat_cur.max_val;
                    stat_samples_next = stat_cur.samples;
                    stat_viol_next    = stat_cur.violations;
                end
            end
            KIND_CHECK: begin
                status_next = status_c;
            end
            default: begin
                status_next = STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            status_reg          <= status_next;
            vec_viol_reg        <= vec_viol_next;
            first_feature_reg   <= first_feature_next;
            first_value_reg     <= first_value_next;
            first_bound_reg     <= first_bound_next;
            first_upper_reg     <= first_upper_next;
            stat_min_reg        <= stat_min_next;
            stat_max_reg        <= stat_max_next;
            stat_samples_reg    <= stat_samples_next;
            stat_viol_reg       <= stat_viol_next;
            win_samples_out_reg <= win_samples_out_next;
            win_viol_out_reg    <= win_viol_out_next;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_status            = status_reg;
    assign m_vector_violations = vec_viol_reg;
    assign m_first_feature     = first_feature_reg;
    assign m_first_value       = first_value_reg;
    assign m_first_bound       = first_bound_reg;
    assign m_first_is_upper    = first_upper_reg;
    assign m_stat_min          = stat_min_reg;
    assign m_stat_max          = stat_max_reg;
    assign m_stat_samples      = stat_samples_reg;
    assign m_stat_violations   = stat_viol_reg;
    assign m_window_vectors    = win_samples_out_reg;
    assign m_window_violations = win_viol_out_reg;

endmodule

`default_nettype wire

// ----- rtl/feature_range_envelope_monitor_top.sv -----
// Top level of the feature range envelope monitor: configuration, memories and stages.
`default_nettype none

// The monitor takes one transaction per clock cycle unless the input stalls: the
// accept cycle issues the memory reads, the update cycle works on the registered read
// data, and the result register presents the answer. Per-feature bounds and statistics
// live in two synchronous RAMs; the statistics entry of a sample element is read,
// updated and written back in the update cycle, and a one-entry forwarding register
// covers a following element of the same feature, so back-to-back elements run at
// full rate even with a feature count of one. A new window clears every statistics
// entry at once through per-entry valid bits, with no clearing pass. The input stalls
// only when the update stage holds a transaction that produces a result while the
// result register is still waiting to be taken. Sample elements answer only on the last
// element of a vector, read-statistics and check transactions always answer, and
// load-bounds and new-window transactions do not. Configuration must be written
// through the plain write port while the block is idle; the block does not enforce it.
module feature_range_envelope_monitor_top import frem_pkg::*; #(
    parameter int MAX_FEATURES = MAX_FEATURES_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [2:0]             s_kind,
    input  wire logic [5:0]             s_feature_index,
    input  wire logic signed [31:0]     s_value,
    input  wire logic signed [31:0]     s_upper_value,
    input  wire logic [63:0]            s_window_label,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [1:0]                  m_status,
    output logic [6:0]                  m_vector_violations,
    output logic [5:0]                  m_first_feature,
    output logic signed [31:0]          m_first_value,
    output logic signed [31:0]          m_first_bound,
    output logic                        m_first_is_upper,
    output logic signed [31:0]          m_stat_min,
    output logic signed [31:0]          m_stat_max,
    output logic [31:0]                 m_stat_samples,
    output logic [31:0]                 m_stat_violations,
    output logic [31:0]                 m_window_vectors,
    output logic [31:0]                 m_window_violations
);

    localparam int ADDR_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

    // Configuration registers.
    logic [FCOUNT_W-1:0] vec_length_reg;
    logic                envelope_enable_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vec_length_reg      <= FCOUNT_W'(1);
            envelope_enable_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_VEC_LENGTH:      vec_length_reg      <= cfg_wdata[FCOUNT_W-1:0];
                REG_ENVELOPE_ENABLE: envelope_enable_reg <= cfg_wdata[0];
                default:             vec_length_reg      <= vec_length_reg;
            endcase
        end
    end

    logic              bound_we;
    logic [ADDR_W-1:0] bound_waddr;
    bound_rec_t        bound_wdata, bound_rdata;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              stat_we;
    logic [ADDR_W-1:0] stat_waddr;
    stat_rec_t         stat_wdata, stat_rdata;
    s1_ctrl_t          s1_ctrl;
    logic [ADDR_W-1:0] s1_addr;
    logic signed [DATA_W-1:0] s1_value;
    logic              s1_fire;

    frem_front #(
        .MAX_FEATURES (MAX_FEATURES),
        .ADDR_W       (ADDR_W)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .vec_length      (vec_length_reg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_feature_index (s_feature_index),
        .s_value         (s_value),
        .s_upper_value   (s_upper_value),
        .s_window_label  (s_window_label),
        .s1_fire         (s1_fire),
        .bound_we        (bound_we),
        .bound_waddr     (bound_waddr),
        .bound_wdata     (bound_wdata),
        .rd_en           (rd_en),
        .rd_addr         (rd_addr),
        .s1              (s1_ctrl),
        .s1_addr         (s1_addr),
        .s1_value        (s1_value)
    );

    // Bounds memory: lower and upper bound of every feature.
    frem_ram #(
        .WIDTH (BOUND_W),
        .DEPTH (MAX_FEATURES),
        .AW    (ADDR_W)
    ) u_bound_ram (
        .aclk  (aclk),
        .we    (bound_we),
        .waddr (bound_waddr),
        .wdata (bound_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (bound_rdata)
    );

    // Statistics memory: minimum, maximum, sample and violation counts per feature.
    frem_ram #(
        .WIDTH (STAT_W),
        .DEPTH (MAX_FEATURES),
        .AW    (ADDR_W)
    ) u_stat_ram (
        .aclk  (aclk),
        .we    (stat_we),
        .waddr (stat_waddr),
        .wdata (stat_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (stat_rdata)
    );

    frem_update #(
        .MAX_FEATURES (MAX_FEATURES),
        .ADDR_W       (ADDR_W)
    ) u_update (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .envelope_enable     (envelope_enable_reg),
        .s1                  (s1_ctrl),
        .s1_addr             (s1_addr),
        .s1_value            (s1_value),
        .stat_rdata          (stat_rdata),
        .bound_rdata         (bound_rdata),
        .stat_we             (stat_we),
        .stat_waddr          (stat_waddr),
        .stat_wdata          (stat_wdata),
        .s1_fire             (s1_fire),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_vector_violations (m_vector_violations),
        .m_first_feature     (m_first_feature),
        .m_first_value       (m_first_value),
        .m_first_bound       (m_first_bound),
        .m_first_is_upper    (m_first_is_upper),
        .m_stat_min          (m_stat_min),
        .m_stat_max          (m_stat_max),
        .m_stat_samples      (m_stat_samples),
        .m_stat_violations   (m_stat_violations),
        .m_window_vectors    (m_window_vectors),
        .m_window_violations (m_window_violations)
    );

`ifndef SYNTH
    // Only a sample element leaving the update stage writes the statistics memory.
    a_stat_write_source: assert property (@(posedge aclk) disable iff (!aresetn)
        stat_we |-> (s1_ctrl.valid && s1_fire && (s1_ctrl.kind == KIND_SAMPLE)))
        else $error("statistics write without a retiring sample element");

    // An accepted transaction always occupies the update stage in the next cycle.
    a_accept_to_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> s1_ctrl.valid)
        else $error("accepted transaction missing from the update stage");

    // A stalled update stage issues no read and keeps its address, so its read data
    // stays matched.
    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_ctrl.valid && !s1_fire) |-> (!rd_en ##1 (s1_ctrl.valid && $stable(s1_addr))))
        else $error("update stage changed while stalled");

    // A result is produced only when the result register can take it.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready && s1_fire) |->
            (s1_ctrl.kind == KIND_LOAD || s1_ctrl.kind == KIND_WINDOW ||
             (s1_ctrl.kind == KIND_SAMPLE && !s1_ctrl.last) ||
             (s1_ctrl.kind != KIND_SAMPLE && s1_ctrl.kind != KIND_READ &&
              s1_ctrl.kind != KIND_CHECK)))
        else $error("waiting result overwritten");
`endif

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the feature range envelope monitor with a transaction-level predictor.
module tb;
    import frem_pkg::*;

    // The block holds a transaction in the update stage and then in the result register, so
    // the DRAIN_CYCLES wait after the last expected result is enough for the pipeline to empty.
    localparam int FEATURES               = MAX_FEATURES_DEF;
    localparam int RESET_CYCLES           = 4;
    localparam int DRAIN_CYCLES           = 8;
    localparam int IDLE_LIMIT             = 2000;
    localparam int RANDOM_PHASES          = 10;
    localparam int RANDOM_ITEMS_PER_PHASE = 156;

    // Kind codes that the block must ignore without answering.
    localparam logic [2:0] KIND_RESERVED_FIRST = 3'd5;
    localparam logic [2:0] KIND_RESERVED_LAST  = 3'd7;

    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

    // One input transaction, field for field as it sits on the s_ ports.
    typedef struct packed {
        logic [2:0]         kind;
        logic [5:0]         feature_index;
        logic signed [31:0] value;
        logic signed [31:0] upper_value;
        logic [63:0]        window_label;
    } monitor_item_t;

    // One result transaction, field for field as it sits on the m_ ports.
    typedef struct packed {
        logic [1:0]         status;
        logic [6:0]         vector_violations;
        logic [5:0]         first_feature;
        logic signed [31:0] first_value;
        logic signed [31:0] first_bound;
        logic               first_is_upper;
        logic signed [31:0] stat_min;
        logic signed [31:0] stat_max;
        logic [31:0]        stat_samples;
        logic [31:0]        stat_violations;
        logic [31:0]        window_vectors;
        logic [31:0]        window_violations;
    } envelope_result_t;

    // Stall patterns of the result receiver.
    typedef enum int unsigned {
        READY_ALWAYS,
        READY_COIN,
        READY_EVERY_FOURTH,
        READY_SPARSE
    } ready_mode_t;

    // Every input of the block starts at a known value.
    logic                    aclk    = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [2:0]              s_kind = '0;
    logic [5:0]              s_feature_index = '0;
    logic signed [31:0]      s_value = '0;
    logic signed [31:0]      s_upper_value = '0;
    logic [63:0]             s_window_label = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [1:0]              m_status;
    logic [6:0]              m_vector_violations;
    logic [5:0]              m_first_feature;
    logic signed [31:0]      m_first_value;
    logic signed [31:0]      m_first_bound;
    logic                    m_first_is_upper;
    logic signed [31:0]      m_stat_min;
    logic signed [31:0]      m_stat_max;
    logic [31:0]             m_stat_samples;
    logic [31:0]             m_stat_violations;
    logic [31:0]             m_window_vectors;
    logic [31:0]             m_window_violations;

    // Transactions waiting for the driver, and results the block still owes.
    monitor_item_t    pending_items[$];
    envelope_result_t expected_results[$];
    int               mismatch_count = 0;

    // Predictor copy of the configuration registers.
    logic [6:0]         vec_length_reg;
    logic               envelope_on;

    // Predictor copy of the per-feature memories and the window totals.
    logic signed [31:0] lower_limit   [FEATURES];
    logic signed [31:0] upper_limit   [FEATURES];
    logic signed [31:0] low_water     [FEATURES];
    logic signed [31:0] high_water    [FEATURES];
    logic [31:0]        feature_hits  [FEATURES];
    logic [31:0]        feature_breaches [FEATURES];
    logic [31:0]        window_vectors;
    logic [31:0]        window_breaches;
    logic [63:0]        window_tag;

    // Predictor copy of the vector in progress.
    int unsigned        vector_slot;
    logic [6:0]         vector_breaches;
    logic               breach_latched;
    logic [5:0]         breach_feature;
    logic signed [31:0] breach_value;
    logic signed [31:0] breach_bound;
    logic               breach_upper;

    // Feature counts and envelope settings of the random phases. The list
    // holds the extremes: zero and values above the feature limit too.
    logic [6:0] phase_counts [RANDOM_PHASES] =
        '{7'd1, 7'd64, 7'd0, 7'd4, 7'd127, 7'd2, 7'd7, 7'd3, 7'd16, 7'd1};
    logic       phase_envelope [RANDOM_PHASES] =
        '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};

    feature_range_envelope_monitor_top dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_kind              (s_kind),
        .s_feature_index     (s_feature_index),
        .s_value             (s_value),
        .s_upper_value       (s_upper_value),
        .s_window_label      (s_window_label),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_vector_violations (m_vector_violations),
        .m_first_feature     (m_first_feature),
        .m_first_value       (m_first_value),
        .m_first_bound       (m_first_bound),
        .m_first_is_upper    (m_first_is_upper),
        .m_stat_min          (m_stat_min),
        .m_stat_max          (m_stat_max),
        .m_stat_samples      (m_stat_samples),
        .m_stat_violations   (m_stat_violations),
        .m_window_vectors    (m_window_vectors),
        .m_window_violations (m_window_violations)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // A count of zero behaves as one feature and a count above the limit as
    // the full set of features.
    function automatic int unsigned features_in_use();
        if (vec_length_reg == 7'd0) return 1;
        if (vec_length_reg > FEATURES) return FEATURES;
        return vec_length_reg;
    endfunction

    task automatic clear_vector_state();
        vector_slot     = 0;
        vector_breaches = '0;
        breach_latched  = 1'b0;
        breach_feature  = '0;
        breach_value    = '0;
        breach_bound    = '0;
        breach_upper    = 1'b0;
    endtask

    task automatic clear_window_stats();
        for (int f = 0; f < FEATURES; f++) begin
            low_water[f]        = MIN_SENTINEL;
            high_water[f]       = MAX_SENTINEL;
            feature_hits[f]     = '0;
            feature_breaches[f] = '0;
        end
        window_vectors  = '0;
        window_breaches = '0;
    endtask

    // The bound memories stay unset on purpose: the stimulus loads every
    // feature before any transaction could look at a bound.
    task automatic reset_predictor();
        vec_length_reg = 7'd1;
        envelope_on    = 1'b0;
        window_tag     = '0;
        clear_window_stats();
        clear_vector_state();
    endtask

    // Applies one accepted transaction to the predictor state and queues the
    // result it causes, if any.
    task automatic predict_envelope(input monitor_item_t it);
        envelope_result_t   r;
        logic signed [31:0] v;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic signed [31:0] crossed;
        logic               hit;
        logic               up;
        int unsigned        cnt;
        int unsigned        p;
        int unsigned        idx;
        r   = '0;
        v   = it.value;
        cnt = features_in_use();
        idx = it.feature_index;
        case (it.kind)
            KIND_SAMPLE: begin
                // The element lands at the current position of the vector,
                // which never runs past the last feature.
                p = (vector_slot >= FEATURES) ? FEATURES - 1 : vector_slot;
                feature_hits[p] += 32'd1;
                if (v < low_water[p]) low_water[p] = v;
                if (v > high_water[p]) high_water[p] = v;
                if (envelope_on) begin
                    lo      = lower_limit[p];
                    hi      = upper_limit[p];
                    hit     = 1'b0;
                    up      = 1'b0;
                    crossed = '0;
                    if (v < lo) begin
                        hit     = 1'b1;
                        crossed = lo;
                    end else if (v > hi) begin
                        hit     = 1'b1;
                        up      = 1'b1;
                        crossed = hi;
                    end
                    if (hit) begin
                        feature_breaches[p] += 32'd1;
                        window_breaches     += 32'd1;
                        vector_breaches     += 7'd1;
                        if (!breach_latched) begin
                            breach_latched = 1'b1;
                            breach_feature = p[5:0];
                            breach_value   = v;
                            breach_bound   = crossed;
                            breach_upper   = up;
                        end
                    end
                end
                // A shrunken feature count ends the vector on the next element.
                if (vector_slot + 1 >= cnt) begin
                    window_vectors     += 32'd1;
                    r.status            = (vector_breaches != 0) ? STATUS_VIOLATION : STATUS_OK;
                    r.vector_violations = vector_breaches;
                    r.first_feature     = breach_feature;
                    r.first_value       = breach_value;
                    r.first_bound       = breach_bound;
                    r.first_is_upper    = breach_upper;
                    clear_vector_state();
                    expected_results.push_back(r);
                end else begin
                    vector_slot++;
                end
            end
            KIND_LOAD: begin
                lower_limit[idx] = it.value;
                upper_limit[idx] = it.upper_value;
            end
            KIND_WINDOW: begin
                window_tag = it.window_label;
                clear_window_stats();
                clear_vector_state();
            end
            KIND_READ: begin
                r.window_vectors    = window_vectors;
                r.window_violations = window_breaches;
                if (idx >= cnt) begin
                    r.status = STATUS_BAD_INDEX;
                end else begin
                    r.stat_min        = low_water[idx];
                    r.stat_max        = high_water[idx];
                    r.stat_samples    = feature_hits[idx];
                    r.stat_violations = feature_breaches[idx];
                end
                expected_results.push_back(r);
            end
            KIND_CHECK: begin
                if (!envelope_on) begin
                    r.status = STATUS_OK;
                end else if (idx >= cnt) begin
                    r.status = STATUS_BAD_INDEX;
                end else begin
                    lo = lower_limit[idx];
                    hi = upper_limit[idx];
                    r.status = (v >= lo && v <= hi) ? STATUS_OK : STATUS_VIOLATION;
                end
                expected_results.push_back(r);
            end
            default: begin
                // Reserved kinds leave every piece of state alone.
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_item(input logic [2:0] kind, input logic [5:0] idx,
                              input logic signed [31:0] value,
                              input logic signed [31:0] upper,
                              input logic [63:0] label);
        monitor_item_t it;
        it.kind          = kind;
        it.feature_index = idx;
        it.value         = value;
        it.upper_value   = upper;
        it.window_label  = label;
        pending_items.push_back(it);
    endtask

    // Sample values cluster around the typical bound range so that both
    // sides of each bound are hit, with extremes and full-range noise mixed in.
    function automatic logic signed [31:0] pick_sample_value();
        logic signed [31:0] w;
        case ($urandom_range(0, 9))
            0:       w = Q_MIN;
            1:       w = Q_MAX;
            2:       w = $urandom_range(0, 2) - 1;
            3, 4:    w = $urandom;
            default: w = $urandom_range(0, 32'h6_0000) - 32'h3_0000;
        endcase
        return w;
    endfunction

    // Returns {upper, lower}. Most pairs are a sane window around zero; some
    // are the full range, random or inverted so that every value violates.
    function automatic logic [63:0] pick_limits();
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        case ($urandom_range(0, 9))
            0: begin
                lo = Q_MIN;
                hi = Q_MAX;
            end
            1: begin
                lo = $urandom;
                hi = $urandom;
            end
            2: begin
                lo = $urandom_range(0, 32'h1_0000);
                hi = lo - 1;
            end
            default: begin
                lo = 32'h0 - $urandom_range(0, 32'h2_8000);
                hi = $urandom_range(0, 32'h2_8000);
            end
        endcase
        return {hi, lo};
    endfunction

    // Mostly sample elements so that vectors complete, with the other kinds
    // sprinkled in. New windows stay rare so that statistics can build up.
    function automatic monitor_item_t random_item();
        monitor_item_t it;
        logic [63:0]   limits;
        int unsigned   roll;
        it.kind          = KIND_SAMPLE;
        it.feature_index = $urandom_range(0, 63);
        it.value         = pick_sample_value();
        it.upper_value   = $urandom;
        it.window_label  = {$urandom, $urandom};
        roll = $urandom_range(0, 99);
        if (roll < 72) begin
            it.kind = KIND_SAMPLE;
        end else if (roll < 78) begin
            it.kind        = KIND_LOAD;
            limits         = pick_limits();
            it.value       = limits[31:0];
            it.upper_value = limits[63:32];
        end else if (roll < 80) begin
            it.kind = KIND_WINDOW;
        end else if (roll < 98) begin
            it.kind = (roll < 89) ? KIND_READ : KIND_CHECK;
            // Half of the reads and checks are steered to an active feature.
            if ($urandom_range(0, 1) != 0)
                it.feature_index = 6'($urandom_range(0, features_in_use() - 1));
        end else begin
            it.kind = 3'($urandom_range(KIND_RESERVED_FIRST, KIND_RESERVED_LAST));
        end
        return it;
    endfunction

    // The predictor follows the register write at once since nothing is in flight
    // when this is called.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        if (idx == REG_VEC_LENGTH)
            vec_length_reg = data;
        else
            envelope_on = data[0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Waits until every queued transaction is accepted and every expected
    // result has come back, then lets the pipeline run empty, since sample
    // elements and loads may still be in flight without owing a result.
    task automatic wait_until_idle();
        while (pending_items.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of transactions with random gaps between them. A
    // transaction is handed to the predictor in the cycle it is accepted.
    // ------------------------------------------------------------------
    monitor_item_t bus_item;
    int unsigned   burst_left = 0;
    int unsigned   gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (s_valid && s_ready)
                predict_envelope(bus_item);
            // The bus is free when nothing is offered or the offer was just
            // taken; otherwise valid and payload hold.
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    bus_item         = pending_items.pop_front();
                    s_valid         <= 1'b1;
                    s_kind          <= bus_item.kind;
                    s_feature_index <= bus_item.feature_index;
                    s_value         <= bus_item.value;
                    s_upper_value   <= bus_item.upper_value;
                    s_window_label  <= bus_item.window_label;
                    if (burst_left != 0) begin
                        burst_left--;
                    end else begin
                        // A quarter of the bursts run straight into the next.
                        burst_left = $urandom_range(0, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: m_ready follows a stall pattern that changes every so often.
    // ------------------------------------------------------------------
    ready_mode_t ready_mode = READY_ALWAYS;
    int unsigned ready_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            ready_left = 0;
        end else begin
            if (ready_left == 0) begin
                ready_mode = ready_mode_t'($urandom_range(0, 3));
                ready_left = $urandom_range(16, 160);
            end else begin
                ready_left--;
            end
            case (ready_mode)
                READY_ALWAYS:       m_ready <= 1'b1;
                READY_COIN:         m_ready <= ($urandom_range(0, 1) != 0);
                READY_EVERY_FOURTH: m_ready <= (ready_left % 4 == 0);
                default:            m_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every accepted result is checked against the oldest
    // expectation, field by field.
    // ------------------------------------------------------------------
    envelope_result_t want;

    task automatic compare_field(input string name, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want_v, got_v);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result transaction with no expectation pending, status %0d",
                       m_status);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                compare_field("status", want.status, m_status);
                compare_field("vector_violations", want.vector_violations,
                              m_vector_violations);
                compare_field("first_feature", want.first_feature, m_first_feature);
                compare_field("first_value", want.first_value, m_first_value);
                compare_field("first_bound", want.first_bound, m_first_bound);
                compare_field("first_is_upper", want.first_is_upper, m_first_is_upper);
                compare_field("stat_min", want.stat_min, m_stat_min);
                compare_field("stat_max", want.stat_max, m_stat_max);
                compare_field("stat_samples", want.stat_samples, m_stat_samples);
                compare_field("stat_violations", want.stat_violations, m_stat_violations);
                compare_field("window_vectors", want.window_vectors, m_window_vectors);
                compare_field("window_violations", want.window_violations,
                              m_window_violations);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: a run in which neither channel moves for too long is hung.
    // ------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial begin
        logic [63:0] limits;
        reset_predictor();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Three-feature vectors with the envelope on for the directed part.
        write_reg(REG_VEC_LENGTH, 7'd3);
        write_reg(REG_ENVELOPE_ENABLE, 7'd1);

        // Load bounds for every feature before anything can read one. The
        // first four get hand-picked windows: the full range, plus or minus
        // one, a single point and an inverted window.
        queue_item(KIND_LOAD, 6'd0, Q_MIN, Q_MAX, '0);
        queue_item(KIND_LOAD, 6'd1, -Q_ONE, Q_ONE, '0);
        queue_item(KIND_LOAD, 6'd2, 32'sd0, 32'sd0, '0);
        queue_item(KIND_LOAD, 6'd3, 32'sd5, -32'sd5, '0);
        for (int f = 4; f < FEATURES; f++) begin
            limits = pick_limits();
            queue_item(KIND_LOAD, 6'(f), limits[31:0], limits[63:32], '0);
        end

        // A vector that crosses the upper bound of feature 1 first and the
        // lower bound of feature 2 after it, then one that sits on the edges.
        queue_item(KIND_SAMPLE, 6'd0, Q_MIN, '0, '0);
        queue_item(KIND_SAMPLE, 6'd0, 2 * Q_ONE, '0, '0);
        queue_item(KIND_SAMPLE, 6'd0, -32'sd1, '0, '0);
        queue_item(KIND_SAMPLE, 6'd0, Q_MAX, '0, '0);
        queue_item(KIND_SAMPLE, 6'd0, -Q_ONE, '0, '0);
        queue_item(KIND_SAMPLE, 6'd0, 32'sd0, '0, '0);

        // Statistics of active features and of indexes past the count.
        queue_item(KIND_READ, 6'd0, '0, '0, '0);
        queue_item(KIND_READ, 6'd1, '0, '0, '0);
        queue_item(KIND_READ, 6'd3, '0, '0, '0);
        queue_item(KIND_READ, 6'd63, '0, '0, '0);

        // Single checks: on the bound, just past it, below a point window,
        // and at a bad index.
        queue_item(KIND_CHECK, 6'd1, Q_ONE, '0, '0);
        queue_item(KIND_CHECK, 6'd1, Q_ONE + 1, '0, '0);
        queue_item(KIND_CHECK, 6'd2, -32'sd1, '0, '0);
        queue_item(KIND_CHECK, 6'd3, 32'sd0, '0, '0);

        // A reload takes effect for the very next check.
        queue_item(KIND_LOAD, 6'd1, Q_MIN, Q_MIN, '0);
        queue_item(KIND_CHECK, 6'd1, -32'sd1, '0, '0);

        for (int k = int'(KIND_RESERVED_FIRST); k <= int'(KIND_RESERVED_LAST); k++)
            queue_item(3'(k), 6'd0, Q_MAX, Q_MIN, '1);

        // A new window brings back the sentinels; then a vector is left half
        // done on purpose.
        queue_item(KIND_WINDOW, 6'd0, '0, '0, '1);
        queue_item(KIND_READ, 6'd0, '0, '0, '0);
        queue_item(KIND_SAMPLE, 6'd0, Q_ONE, '0, '0);
        wait_until_idle();

        // Shrinking the count below the current position ends the vector on
        // the next element.
        write_reg(REG_VEC_LENGTH, 7'd1);
        queue_item(KIND_SAMPLE, 6'd0, -Q_ONE, '0, '0);
        wait_until_idle();

        // With the envelope off every check passes, bad index or not.
        write_reg(REG_ENVELOPE_ENABLE, 7'd0);
        queue_item(KIND_CHECK, 6'd2, -32'sd1, '0, '0);
        queue_item(KIND_CHECK, 6'd63, Q_MIN, '0, '0);

        // Random phases, each under a setting of its own. Partial vectors
        // carry over from one phase into the next on purpose.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_until_idle();
            write_reg(REG_VEC_LENGTH, phase_counts[ph]);
            write_reg(REG_ENVELOPE_ENABLE, {6'd0, phase_envelope[ph]});
            for (int n = 0; n < RANDOM_ITEMS_PER_PHASE; n++)
                pending_items.push_back(random_item());
        end

        wait_until_idle();
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
